/* sv/fbm_pkg.sv */
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared types and constants for the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbm_pkg;

    localparam int BITMAP_WORDS = 32768;
    localparam int WORD_W       = 32;
    localparam int WAW          = $clog2(BITMAP_WORDS);   // word index width
    localparam int WCW          = WAW + 1;                // word count width
    localparam int BIT_W        = $clog2(WORD_W);
    localparam int KIND_W       = 2;
    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 21;
    localparam int FRAME_W      = 20;
    localparam int PAGE_SHIFT   = 12;
    localparam int QWORD_W      = ADDR_W - PAGE_SHIFT - BIT_W;
    localparam int FULL_W       = COUNT_W - BIT_W;

    localparam logic [ADDR_W-1:0] PTE_FLAGS = 32'h0000_0007;  // present, writable, user

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  byte_addr;
        logic [COUNT_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic [ADDR_W-1:0]  page_entry;
        logic               is_free;
        logic               out_of_frames;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic alloc_start;
        logic scan;
        logic alloc_commit;
        logic query_rd;
        logic query_chk;
        logic rsv_start;
        logic rsv_step;
        logic rsv_last;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_found;
        logic scan_empty;
        logic rsv_at_lim;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/frame_bitmap_allocator.sv */
// Steps: query reads a bitmap word, checks the bit, then loads the result; allocate
//   scans from the search hint (the hint points at the lowest word that may hold a free
//   frame) and writes the word back; reserve writes one bitmap word per cycle.
// Throughput: one item in flight; the next beat is taken once the result enters
//   the output register, which may still be waiting on the consumer.
// Reset: synchronous, active low; a fill count makes the whole bitmap read as free
//   right after reset with no clearing pass; input is taken once reset is released.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit physical frame allocator over a 1 bit per frame bitmap in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire fbm_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output fbm_pkg::t_out_item      o_out_data
);

    fbm_pkg::t_cmd cmd;
    fbm_pkg::t_sts sts;

    fbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fbm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* sv/fbm_ram.sv */
// ----------------------------------------------------------------------------
// fbm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/fbm_ctrl.sv */
// ----------------------------------------------------------------------------
// fbm_ctrl
// Sequencer for allocate, query and reserve; drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [fbm_pkg::KIND_W-1:0]  i_kind,
    output logic                             o_in_ready,
    input  wire fbm_pkg::t_sts               i_sts,
    output fbm_pkg::t_cmd                    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_AWR   = 3'd2;
    localparam logic [2:0] ST_QRD   = 3'd3;
    localparam logic [2:0] ST_QCHK  = 3'd4;
    localparam logic [2:0] ST_RFILL = 3'd5;
    localparam logic [2:0] ST_RLAST = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // no beat is taken while reset is held
    assign o_in_ready = i_rst_n && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_kind)
                        fbm_pkg::KIND_ALLOC: begin
                            o_cmd.alloc_start = 1'b1;
                            n_state = ST_SCAN;
                        end
                        fbm_pkg::KIND_QUERY: begin
                            n_state = ST_QRD;
                        end
                        fbm_pkg::KIND_RESERVE: begin
                            o_cmd.rsv_start = 1'b1;
                            n_state = ST_RFILL;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_found) begin
                    n_state = ST_AWR;
                end else if (i_sts.scan_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_AWR: begin
                o_cmd.alloc_commit = 1'b1;
                n_state = ST_DONE;
            end
            ST_QRD: begin
                o_cmd.query_rd = 1'b1;
                n_state = ST_QCHK;
            end
            ST_QCHK: begin
                o_cmd.query_chk = 1'b1;
                n_state = ST_DONE;
            end
            ST_RFILL: begin
                if (i_sts.rsv_at_lim) begin
                    n_state = ST_RLAST;
                end else begin
                    o_cmd.rsv_step = 1'b1;
                end
            end
            ST_RLAST: begin
                o_cmd.rsv_last = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* sv/fbm_dpath.sv */
// ----------------------------------------------------------------------------
// fbm_dpath
// Bitmap RAM, scan pointer, search hint, fill count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fbm_pkg::t_in_item  i_in_data,
    input  wire fbm_pkg::t_cmd      i_cmd,
    output fbm_pkg::t_sts           o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output fbm_pkg::t_out_item      o_out_data
);

    localparam logic [fbm_pkg::WCW-1:0] WORDS_C = fbm_pkg::WCW'(fbm_pkg::BITMAP_WORDS);

    function automatic logic [fbm_pkg::BIT_W-1:0] f_lowest(
        input logic [fbm_pkg::WORD_W-1:0] v
    );
        logic [fbm_pkg::BIT_W-1:0] n;
        n = '0;
        for (int i = fbm_pkg::WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = fbm_pkg::BIT_W'(i);
            end
        end
        return n;
    endfunction

    // scan / search state
    logic [fbm_pkg::WCW-1:0]     r_addr;
    logic [fbm_pkg::WAW-1:0]     r_rd_addr;
    logic                        r_chk_vld;
    logic [fbm_pkg::WAW-1:0]     r_waddr;
    logic [fbm_pkg::WORD_W-1:0]  r_wdata;
    // all words below the hint are full; words at or above the fill count read as zero
    logic [fbm_pkg::WCW-1:0]     r_hint;
    logic [fbm_pkg::WCW-1:0]     r_fill;
    // captured item fields
    logic [fbm_pkg::QWORD_W-1:0] r_q_word;
    logic [fbm_pkg::BIT_W-1:0]   r_q_bit;
    logic [fbm_pkg::WCW-1:0]     r_lim;
    logic                        r_full_in;
    logic [fbm_pkg::WAW-1:0]     r_full_idx;
    logic [fbm_pkg::BIT_W-1:0]   r_rem;
    // result
    fbm_pkg::t_out_item          r_res;
    fbm_pkg::t_out_item          r_out;
    logic                        r_out_vld;

    logic                        ram_we;
    logic [fbm_pkg::WAW-1:0]     ram_waddr;
    logic [fbm_pkg::WORD_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [fbm_pkg::WAW-1:0]     ram_raddr;
    logic [fbm_pkg::WORD_W-1:0]  ram_rdata;

    logic [fbm_pkg::WORD_W-1:0]  word_eff;
    logic [fbm_pkg::WORD_W-1:0]  avail;
    logic [fbm_pkg::BIT_W-1:0]   low_bit;
    logic [fbm_pkg::FRAME_W-1:0] new_frame;
    logic                        addr_in;
    logic                        found;
    logic                        empty;
    logic [fbm_pkg::FULL_W-1:0]  in_full;
    logic                        in_full_in;
    logic [fbm_pkg::WCW-1:0]     commit_fill;
    logic [fbm_pkg::WCW-1:0]     rsv_fill;
    logic                        q_in_range;

    assign word_eff  = ({1'b0, r_rd_addr} < r_fill) ? ram_rdata : '0;
    assign avail     = ~word_eff;
    assign low_bit   = f_lowest(avail);
    assign new_frame = fbm_pkg::FRAME_W'({r_rd_addr, low_bit});
    assign addr_in   = (r_addr < WORDS_C);
    assign found     = r_chk_vld && (avail != '0);
    assign empty     = !r_chk_vld && (r_addr == WORDS_C);

    assign in_full    = i_in_data.count[fbm_pkg::COUNT_W-1:fbm_pkg::BIT_W];
    assign in_full_in = (in_full < fbm_pkg::FULL_W'(fbm_pkg::BITMAP_WORDS));

    assign commit_fill = fbm_pkg::WCW'({1'b0, r_waddr}) + fbm_pkg::WCW'(1);
    assign rsv_fill    = r_full_in ? (r_lim + fbm_pkg::WCW'(1)) : r_lim;
    assign q_in_range  = ({1'b0, r_q_word} < (fbm_pkg::QWORD_W + 1)'(fbm_pkg::BITMAP_WORDS));

    assign o_sts.scan_found = found;
    assign o_sts.scan_empty = empty;
    assign o_sts.rsv_at_lim = (r_addr == r_lim);
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    assign ram_re    = (i_cmd.scan && addr_in) || i_cmd.query_rd;
    assign ram_raddr = i_cmd.query_rd ? r_q_word[fbm_pkg::WAW-1:0] : r_addr[fbm_pkg::WAW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr[fbm_pkg::WAW-1:0];
        ram_wdata = '1;
        if (i_cmd.alloc_commit) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr;
            ram_wdata = r_wdata;
        end else if (i_cmd.rsv_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.rsv_last && r_full_in) begin
            // partial word: low rem bits used, the rest cleared
            ram_we    = 1'b1;
            ram_waddr = r_full_idx;
            ram_wdata = (fbm_pkg::WORD_W'(1) << r_rem) - fbm_pkg::WORD_W'(1);
        end
    end

    fbm_ram #(
        .WIDTH (fbm_pkg::WORD_W),
        .DEPTH (fbm_pkg::BITMAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
            r_hint    <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.alloc_start) begin
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_vld <= addr_in;
            end
            if (i_cmd.scan && empty) begin
                r_hint <= WORDS_C;
            end else if (i_cmd.alloc_commit) begin
                r_hint <= fbm_pkg::WCW'({1'b0, r_waddr});
                if (commit_fill > r_fill) begin
                    r_fill <= commit_fill;
                end
            end else if (i_cmd.rsv_last) begin
                r_hint <= r_lim;
                if (rsv_fill > r_fill) begin
                    r_fill <= rsv_fill;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q_word   <= i_in_data.byte_addr[fbm_pkg::ADDR_W-1 -: fbm_pkg::QWORD_W];
            r_q_bit    <= i_in_data.byte_addr[fbm_pkg::PAGE_SHIFT +: fbm_pkg::BIT_W];
            r_rem      <= i_in_data.count[fbm_pkg::BIT_W-1:0];
            r_full_in  <= in_full_in;
            r_full_idx <= in_full[fbm_pkg::WAW-1:0];
            r_lim      <= in_full_in ? fbm_pkg::WCW'(in_full) : WORDS_C;
            r_res      <= '0;
        end
        if (i_cmd.alloc_start) begin
            r_addr <= r_hint;
        end else if (i_cmd.rsv_start) begin
            r_addr <= '0;
        end else if ((i_cmd.scan && addr_in) || i_cmd.rsv_step) begin
            r_addr <= r_addr + fbm_pkg::WCW'(1);
        end
        if (ram_re) begin
            r_rd_addr <= ram_raddr;
        end
        if (i_cmd.scan && found) begin
            r_waddr            <= r_rd_addr;
            r_wdata            <= word_eff | (fbm_pkg::WORD_W'(1) << low_bit);
            r_res.frame_number <= new_frame;
            r_res.page_entry   <= (fbm_pkg::ADDR_W'(new_frame) << fbm_pkg::PAGE_SHIFT)
                                  | fbm_pkg::PTE_FLAGS;
        end else if (i_cmd.scan && empty) begin
            r_res.out_of_frames <= 1'b1;
        end
        if (i_cmd.query_chk) begin
            r_res.is_free <= q_in_range && !word_eff[r_q_bit];
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* sv/fbm_chk.sv */
// ----------------------------------------------------------------------------
// fbm_chk
// Port-level checks for the frame bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire fbm_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire fbm_pkg::t_out_item o_out_data
);

    // output register is empty coming out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: no second beat right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // a failed allocate gives no frame
    a_oof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_of_frames |->
            o_out_data.frame_number == '0 && o_out_data.page_entry == '0
            && !o_out_data.is_free)
        else $error("out of frames with a frame or free flag");

    // page entry is the frame address with the flags
    a_entry_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.page_entry != '0 |->
            o_out_data.page_entry[31:12] == o_out_data.frame_number
            && o_out_data.page_entry[11:0] == 12'h007)
        else $error("page entry does not match frame number");

endmodule

bind frame_bitmap_allocator fbm_chk u_fbm_chk (.*);

`default_nettype wire
